/* src/spq_pkg.sv */
// Shared types, constants and codes of the stable priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package spq_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned PrioBitsDef  = 8;
  localparam int unsigned PrioReqWidth = 8;
  localparam int unsigned ElemWidth    = 32;

  // Command codes carried on command_i.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;     // capture a new item, index takes the entry count
    logic    rd_en;    // read a slot
    logic    rd_head;  // read the head slot rather than the one below the index
    logic    wr_en;    // write the slot at the index
    logic    wr_new;   // write the new entry rather than the moved one
    logic    idx_dec;  // step the index one slot towards the head
    logic    push;     // one more entry stored
    logic    pop;      // head entry taken out
    logic    finish;   // publish the result
    status_e fin_status;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
    logic idx_zero;
    logic rd_gt;      // slot read last cycle has a greater priority
  } spq_stat_t;

endpackage

/* src/stable_priority_queue.sv */
// Top level of the stable priority queue: controller plus datapath.
// Needs spq_pkg, spq_ctrl, spq_datapath and spq_ram.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------
//   request  | start in, busy out         | command_i, priority_req_i, element_i
//   result   | done_o, one-cycle strobe   | status_o, element_out_o
//
// Each item yields exactly one result, shown on status_o and element_out_o for
// the single cycle in which done_o is high. The receiver cannot stall, so the
// result is simply presented and gone.
// An insert into a full queue or a remove from an empty one is finished in the
// dispatch state, and any other remove reads the head slot there and is finished
// in the pop state. An insert walks through the k stored entries of strictly
// greater priority; each of the k entries is read and moved one slot towards the
// tail through the single read and write port of the slot RAM, and the entry that
// stops the walk costs one further read.
// busy is high from acceptance until the result is registered, so a new item
// may be accepted in the same cycle as the previous result is strobed.
// Reset clears the entry count, the head pointer and the controller; slot
// contents are left alone, as only slots below the entry count are ever read.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH         = DepthDef,
  parameter int unsigned PRIORITY_BITS = PrioBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic [PrioReqWidth-1:0] priority_req_i,
  input  logic [ElemWidth-1:0]    element_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [ElemWidth-1:0]    element_out_o
);

  // The controller sequences each item; the datapath keeps the entries
  // sorted in a ring of slots whose head holds the lowest priority value.
  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // An insert walks from the tail towards the head, moving every entry with
  // a greater priority up by one slot, and drops the new entry into the gap.
  // Entries of equal priority are never passed, which keeps them in arrival
  // order. A remove reads the head slot and advances the head pointer.
  spq_datapath #(
    .DEPTH        (DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .priority_req_i(priority_req_i),
    .element_i     (element_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .element_out_o (element_out_o)
  );

endmodule

/* src/spq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the queue datapath for the slot store.
module spq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/spq_datapath.sv */
// Datapath of the stable priority queue: slot RAM used as a ring, head
// pointer, entry count, scan index and result registers. Needs spq_pkg, spq_ram.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH         = DepthDef,
  parameter int unsigned PRIORITY_BITS = PrioBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_cmd_t                cmd_i,
  output spq_stat_t               stat_o,
  input  logic                    command_i,
  input  logic [PrioReqWidth-1:0] priority_req_i,
  input  logic [ElemWidth-1:0]    element_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [ElemWidth-1:0]    element_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = PRIORITY_BITS + ElemWidth;

  logic                     cmd_q;
  logic [PRIORITY_BITS-1:0] pri_q;
  logic [ElemWidth-1:0]     elem_q;
  logic [CW-1:0]            idx_q;
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            head_q, head_d;
  status_e                  status_q;
  logic [ElemWidth-1:0]     elem_out_q;
  logic                     done_q;

  logic [CW-1:0]            idx_m1;
  logic [AW-1:0]            rd_off;
  logic [AW:0]              rd_sum, wr_sum;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [DW-1:0]            wr_data, rd_data;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [ElemWidth-1:0]     rd_elem;

  // Slot addresses are offsets from the head, wrapped round the ring.
  assign idx_m1  = idx_q - 1'b1;
  assign rd_off  = cmd_i.rd_head ? '0 : idx_m1[AW-1:0];
  assign rd_sum  = {1'b0, head_q} + {1'b0, rd_off};
  assign wr_sum  = {1'b0, head_q} + {1'b0, idx_q[AW-1:0]};
  assign rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : rd_sum[AW-1:0];
  assign wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : wr_sum[AW-1:0];

  assign rd_pri  = rd_data[DW-1:ElemWidth];
  assign rd_elem = rd_data[ElemWidth-1:0];
  assign wr_data = cmd_i.wr_new ? {pri_q, elem_q} : rd_data;

  spq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      pri_q  <= PRIORITY_BITS'(priority_req_i);
      elem_q <= element_i;
      idx_q  <= count_q;
    end else if (cmd_i.idx_dec) begin
      idx_q  <= idx_m1;
    end
    if (cmd_i.finish) begin
      status_q   <= cmd_i.fin_status;
      elem_out_q <= cmd_i.pop ? rd_elem : '0;
    end
  end

  assign stat_o.is_remove = (cmd_q == CMD_REMOVE);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.idx_zero  = (idx_q == '0);
  assign stat_o.rd_gt     = (rd_pri > pri_q);

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign element_out_o = elem_out_q;

endmodule

/* src/spq_ctrl.sv */
// Controller state machine of the stable priority queue.
// Drives the datapath through spq_cmd_t and watches spq_stat_t; needs spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  spq_stat_t stat_i,
  output spq_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CMP,
    S_POP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    cmd_o.fin_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start && !busy_q) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_remove) begin
          if (stat_i.empty) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_EMPTY;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_head = 1'b1;
          end
        end else if (stat_i.full) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_FULL;
        end
        if (cmd_o.finish) begin
          busy_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = stat_i.is_remove ? S_POP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_new = 1'b1;
          cmd_o.push   = 1'b1;
          cmd_o.finish = 1'b1;
          busy_d       = 1'b0;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.rd_gt) begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_SCAN;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.push   = 1'b1;
          cmd_o.finish = 1'b1;
          busy_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.pop    = 1'b1;
        cmd_o.finish = 1'b1;
        busy_d       = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        busy_d  = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the stable priority queue: directed and random insert and
// remove items, results predicted by a shadow sorted list. Depends on spq_pkg and the RTL.
module testbench;
  import spq_pkg::*;

  localparam int unsigned QueueDepth = DepthDef;
  localparam int unsigned PrioBits   = PrioBitsDef;

  // Only the low PrioBits bits of a requested priority are kept by the queue.
  localparam logic [63:0] PrioMask64 = (64'd1 << PrioBits) - 64'd1;

  localparam int RandomItems   = 1200;
  localparam int SettleCycles  = 40;
  localparam int ReportLimit   = 10;

  typedef struct packed {
    logic                    cmd;
    logic [PrioReqWidth-1:0] prio;
    logic [ElemWidth-1:0]    elem;
  } queue_req_t;

  typedef struct packed {
    status_e              status;
    logic [ElemWidth-1:0] elem;
  } queue_outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [ElemWidth-1:0]    element_out_o;
  queue_req_t              drive_req = '0;

  // Items waiting to be offered, and outcomes waiting for their result strobe.
  queue_req_t     req_backlog[$];
  queue_outcome_t outcome_q[$];

  // Shadow copy of the sorted list held by the block; slot 0 is the head.
  logic [PrioReqWidth-1:0] shadow_prio [QueueDepth];
  logic [ElemWidth-1:0]    shadow_elem [QueueDepth];
  int unsigned             shadow_count = 0;

  logic took_item = 1'b0;
  int   idle_left = 0;
  int   calm_left = 0;
  bit   calm_on   = 1'b0;

  int fault_count   = 0;
  int items_taken   = 0;
  int stored_count  = 0;
  int refused_count = 0;
  int popped_count  = 0;
  int empty_count   = 0;
  int peak_fill     = 0;

  stable_priority_queue #(
    .DEPTH        (QueueDepth),
    .PRIORITY_BITS(PrioBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (drive_req.cmd),
    .priority_req_i(drive_req.prio),
    .element_i     (drive_req.elem),
    .done_o        (done_o),
    .status_o      (status_o),
    .element_out_o (element_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reset is held low from time zero and released on a falling edge, once only.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one accepted item to the shadow list and returns the result it must produce.
  // An insert goes behind every entry of lower or equal priority, which keeps equal
  // priorities in arrival order; a remove takes the head.
  function automatic queue_outcome_t step_shadow_queue(queue_req_t req);
    queue_outcome_t          outcome;
    logic [PrioReqWidth-1:0] prio;
    int unsigned             pos;
    prio    = req.prio & PrioMask64[PrioReqWidth-1:0];
    outcome = '{status: ST_OK, elem: '0};
    if (req.cmd == CMD_INSERT) begin
      if (shadow_count >= QueueDepth) begin
        outcome.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_elem[i] = shadow_elem[i-1];
        end
        shadow_prio[pos] = prio;
        shadow_elem[pos] = req.elem;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        outcome.status = ST_EMPTY;
      end else begin
        outcome.elem = shadow_elem[0];
        for (int unsigned i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_elem[i-1] = shadow_elem[i];
        end
        shadow_count--;
      end
    end
    return outcome;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= ReportLimit) $display("%s", msg);
  endtask

  task automatic queue_insert(input logic [PrioReqWidth-1:0] prio,
                              input logic [ElemWidth-1:0] elem);
    req_backlog.push_back('{cmd: CMD_INSERT, prio: prio, elem: elem});
  endtask

  // The priority and handle of a remove are ignored by the block, so they carry noise.
  task automatic queue_remove();
    req_backlog.push_back('{cmd: CMD_REMOVE, prio: PrioReqWidth'($urandom), elem: $urandom});
  endtask

  // Length of the pause after an item. The sender alternates between calm stretches,
  // in which it offers back to back, and stretches of mostly short and some long gaps.
  function automatic int next_gap();
    int roll;
    if (calm_left == 0) begin
      calm_left = $urandom_range(10, 60);
      calm_on   = ($urandom_range(0, 3) == 0);
    end
    calm_left--;
    if (calm_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver. An item offered is held until the block takes it; after that the sender
  // waits out its gap before offering the next one. start gets one assignment per edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      start <= 1'b1;
    end else if (idle_left != 0) begin
      start     <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (req_backlog.size() != 0) begin
      drive_req <= req_backlog.pop_front();
      start     <= 1'b1;
      idle_left <= next_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor. Results are checked before the item taken at the same edge is predicted;
  // a result always belongs to an item accepted at an earlier edge.
  always @(posedge clk_i) begin : result_check
    queue_outcome_t want;
    if (done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        note_fault($sformatf("Result with nothing outstanding: status %0d, element %h",
                             status_o, element_out_o));
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status || element_out_o !== want.elem) begin
          note_fault($sformatf("Mismatch: status %0d element %h, expected status %0d element %h",
                               status_o, element_out_o, want.status, want.elem));
        end
        case (want.status)
          ST_FULL: begin
            refused_count++;
          end
          ST_EMPTY: begin
            empty_count++;
          end
          default: begin
          end
        endcase
      end
    end
    took_item <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      want = step_shadow_queue(drive_req);
      outcome_q.push_back(want);
      items_taken++;
      if (want.status == ST_OK) begin
        if (drive_req.cmd == CMD_INSERT) stored_count++;
        else popped_count++;
      end
      if (shadow_count > peak_fill) peak_fill = shadow_count;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int made;
    int seg_len;
    int insert_pct;
    int prio_mode;
    int prio_base;
    logic [PrioReqWidth-1:0] prio;

    // Directed part: remove from an empty queue, equal priorities that must leave in
    // arrival order, the lowest and highest priority and handle values, a run of falling
    // priorities so that each insert shifts every earlier entry of the run, an insert into a full queue,
    // then removes and an insert at the tail.
    queue_remove();
    queue_insert(8'd128, 32'h0000_0000);
    queue_insert(8'd128, 32'hFFFF_FFFF);
    queue_insert(8'd255, 32'h5555_5555);
    queue_insert(8'd0,   32'hAAAA_AAAA);
    for (int i = 0; i < 12; i++) begin
      queue_insert(PrioReqWidth'(200 - 16 * i), $urandom);
    end
    queue_insert(8'd64, 32'hDEAD_0001);
    repeat (3) queue_remove();
    queue_insert(8'd255, $urandom);
    queue_insert(8'd0, $urandom);
    repeat (2) queue_remove();

    // Random part, in segments that lean towards filling, draining or neither, so that
    // the queue often runs full and empty. Priorities come from the full range, from a
    // narrow band that makes many ties, or from the two extremes.
    made = 0;
    while (made < RandomItems) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      prio_mode = $urandom_range(0, 2);
      prio_base = $urandom_range(0, 252);
      for (int i = 0; i < seg_len && made < RandomItems; i++) begin
        case (prio_mode)
          0:       prio = PrioReqWidth'($urandom);
          1:       prio = PrioReqWidth'(prio_base + $urandom_range(0, 3));
          default: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
        if ($urandom_range(0, 99) < insert_pct) queue_insert(prio, $urandom);
        else queue_remove();
        made++;
      end
    end

    // Let the backlog drain, then every outstanding result arrive, then a quiet spell
    // long enough for the slowest insert to show any stray result.
    while (req_backlog.size() != 0 || start) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (outcome_q.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", outcome_q.size()));
    end

    $display("Ran %0d items: %0d inserts stored, %0d refused as full, %0d handles removed,",
             items_taken, stored_count, refused_count, popped_count);
    $display("%0d removes from an empty queue; deepest fill %0d of %0d, %0d faults.",
             empty_count, peak_fill, QueueDepth, fault_count);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of every insert shifting the full list
  // and every gap at its longest.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
